// ----- sv/hotp_pkg.sv -----
// Shared types, constants and helpers for the HOTP/TOTP code generator.
`timescale 1ns / 1ps
package hotp_pkg;
	localparam int KEY_BYTES_DEF = 32;
	localparam int KEY_STORE_BYTES = 32;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_KLEN = 3'd4;
	localparam logic [2:0] REG_STEP = 3'd5;
	localparam logic [2:0] REG_CTR  = 3'd6;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_FOLD, ST_TRUNC, ST_MOD, ST_OUT
	} state_t;

	// block source selector for the SHA-1 load
	typedef enum logic [1:0] {
		BLK_IPAD, BLK_MSG, BLK_OPAD, BLK_INNER
	} blk_sel_t;

	typedef struct packed {
		logic     start_div;
		logic     load;
		blk_sel_t blk;
		logic     init_h;
		logic     round;
		logic     fold;
		logic     trunc;
		logic     mod_step;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic round_last;
		logic mod_done;
	} sts_t;

	function automatic logic [31:0] pow10(input logic [3:0] d);
		logic [31:0] r;
		case (d)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

// ----- sv/hotp_ctrl.sv -----
// Sequencer: division in timestamp mode, four SHA-1 blocks, truncation and decimal reduction.
`timescale 1ns / 1ps
module hotp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             func,
	input  logic             out_taken,
	input  hotp_pkg::sts_t   sts,
	output hotp_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             out_valid
);
	hotp_pkg::state_t state_q, state_nx;
	logic [1:0] blk_q, blk_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hotp_pkg::ST_IDLE;
			blk_q <= 2'd0;
		end else begin
			state_q <= state_nx;
			blk_q <= blk_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		blk_nx = blk_q;
		cmd = '0;
		cmd.blk = hotp_pkg::blk_sel_t'(blk_q);
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			hotp_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.start_div = 1'b1;
					blk_nx = 2'd0;
					state_nx = func ? hotp_pkg::ST_DIV : hotp_pkg::ST_LOAD;
				end
			end
			hotp_pkg::ST_DIV: if (sts.div_done) state_nx = hotp_pkg::ST_LOAD;
			hotp_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				cmd.init_h = (blk_q == 2'd0) || (blk_q == 2'd2);
				state_nx = hotp_pkg::ST_ROUND;
			end
			hotp_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_last) state_nx = hotp_pkg::ST_FOLD;
			end
			hotp_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				blk_nx = blk_q + 2'd1;
				state_nx = (blk_q == 2'd3) ? hotp_pkg::ST_TRUNC : hotp_pkg::ST_LOAD;
			end
			hotp_pkg::ST_TRUNC: begin
				cmd.trunc = 1'b1;
				state_nx = hotp_pkg::ST_MOD;
			end
			hotp_pkg::ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) state_nx = hotp_pkg::ST_OUT;
			end
			hotp_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_taken) state_nx = hotp_pkg::ST_IDLE;
			end
			default: state_nx = hotp_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- sv/hotp_dp.sv -----
// Datapath: restoring divider, SHA-1 round unit with schedule, truncation, modulo.
`timescale 1ns / 1ps
module hotp_dp #(
	parameter int KEY_BYTES = hotp_pkg::KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hotp_pkg::cmd_t       cmd,
	output hotp_pkg::sts_t       sts,
	input  logic                 func,
	input  logic [31:0]          moving_value,
	input  logic [3:0]           digit_count,
	input  logic [255:0]         key,
	input  logic [5:0]           key_length,
	input  logic [31:0]          time_step,
	input  logic [31:0]          init_counter,
	output logic [30:0]          code
);
	// division
	logic [31:0] quo_q, rem_q, ts_q;
	logic [5:0]  dcnt_q;
	logic        div_busy_q;
	logic [32:0] dtrial;
	logic [31:0] factor_q;
	// sha
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0]  rnd_q;
	logic [3:0]  dig_q;
	logic [159:0] inner_q;
	// mod
	logic [31:0] v_q, m_q;
	logic [5:0]  mcnt_q;

	logic [5:0] klen;
	assign klen = ({1'b0, key_length} > 7'(KEY_BYTES)) ? 6'(KEY_BYTES) : key_length;

	assign dtrial = {rem_q, quo_q[31]} - {1'b0, ts_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.start_div) begin
			div_busy_q <= func;
			dcnt_q <= '0;
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q + 6'd1;
			if (dcnt_q == 6'd31) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			quo_q <= moving_value;
			rem_q <= '0;
			ts_q <= time_step;
			factor_q <= init_counter + moving_value;
			dig_q <= digit_count;
		end else if (div_busy_q) begin
			if (!dtrial[32]) begin
				rem_q <= dtrial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
			// zero divisor: every trial succeeds, so quotient is all ones
			if (dcnt_q == 6'd31)
				factor_q <= (!dtrial[32]) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
		end
	end

	// key bytes with padding constant
	function automatic logic [511:0] pad_blk(input logic [7:0] p, input logic [255:0] k,
		input logic [5:0] len);
		logic [511:0] r;
		logic [7:0] kb;
		for (int i = 0; i < 64; i++) begin
			kb = (i < 32 && 6'(i) < len) ? k[255 - 8*(i % 32) -: 8] : 8'h00;
			r[511 - 8*i -: 8] = kb ^ p;
		end
		return r;
	endfunction

	logic [511:0] blk;
	logic [159:0] hcat;
	assign hcat = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
	always_comb begin
		case (cmd.blk)
			hotp_pkg::BLK_IPAD: blk = pad_blk(8'h36, key, klen);
			hotp_pkg::BLK_OPAD: blk = pad_blk(8'h5C, key, klen);
			hotp_pkg::BLK_MSG: blk = {32'd0, factor_q, 8'h80, 376'd0, 64'd576};
			hotp_pkg::BLK_INNER: blk = {inner_q, 8'h80, 280'd0, 64'd672};
			default: blk = '0;
		endcase
	end

	logic [31:0] f, k, t, wn;
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rnd_q <= '0;
		else if (cmd.load) rnd_q <= '0;
		else if (cmd.round) rnd_q <= rnd_q + 7'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511 - 32*i -: 32];
			if (cmd.init_h) begin
				h_q[0] <= hotp_pkg::H0; h_q[1] <= hotp_pkg::H1; h_q[2] <= hotp_pkg::H2;
				h_q[3] <= hotp_pkg::H3; h_q[4] <= hotp_pkg::H4;
				a_q <= hotp_pkg::H0; b_q <= hotp_pkg::H1; c_q <= hotp_pkg::H2;
				d_q <= hotp_pkg::H3; e_q <= hotp_pkg::H4;
			end else begin
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= {wn[30:0], wn[31]};
			e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= t;
		end else if (cmd.fold) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
			// inner digest kept aside, the outer hash restarts the chaining values
			if (cmd.blk == hotp_pkg::BLK_MSG)
				inner_q <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q,
					h_q[4] + e_q};
		end
	end

	// truncation then shift-subtract modulo
	logic [3:0] off;
	logic [31:0] mtrial_m;
	assign off = hcat[3:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mcnt_q <= '0;
		else if (cmd.trunc) mcnt_q <= '0;
		else if (cmd.mod_step) mcnt_q <= mcnt_q + 6'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.trunc) begin
			v_q <= hcat[159 - 8*off -: 32] & 32'h7FFFFFFF;
			m_q <= hotp_pkg::pow10(dig_q);
		end else if (cmd.mod_step && m_q != 32'd0) begin
			// subtract m<<(31-i) where it fits; v below 2^31
			if ((64'(m_q) << (6'd31 - mcnt_q)) <= 64'(v_q))
				v_q <= v_q - mtrial_m;
		end
	end
	assign mtrial_m = m_q << (6'd31 - mcnt_q);
	assign sts = '{div_done: div_busy_q && (dcnt_q == 6'd31),
		round_last: (rnd_q == 7'd79), mod_done: (mcnt_q == 6'd31)};
	assign code = v_q[30:0];
endmodule

// ----- sv/hotp_totp_code_generator_core.sv -----
// Top level: config registers, stream ports, controller and datapath.
//  channel | dir | handshake        | content
//  s_axis  | in  | tvalid/tready    | tuser=func, tdata={digit_count,moving_value}
//  m_axis  | out | tvalid/tready    | tdata=code
//  cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
// Four SHA-1 blocks (load, 80 rounds, fold), a truncation step and the modulo
// steps run per request in counter mode; timestamp mode runs the divider first.
// The next request beat can be accepted in the cycle after the result beat.
// Reset clears the controller and loads register defaults. One request at a
// time; a stalled result holds in m_axis_tdata and keeps s_axis_tready low.
`timescale 1ns / 1ps
module hotp_totp_code_generator_core #(
	parameter int KEY_BYTES = hotp_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // moving_value[31:0], digit_count[35:32]
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // code[30:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [255:0] key_q;
	logic [5:0]   klen_q;
	logic [31:0]  step_q, ctr_q;
	hotp_pkg::cmd_t cmd;
	hotp_pkg::sts_t sts;
	logic busy, start;
	logic [30:0] code;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0; klen_q <= 6'd20; step_q <= 32'd30; ctr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hotp_pkg::REG_KEY0: key_q[255:192] <= cfg_data;
				hotp_pkg::REG_KEY1: key_q[191:128] <= cfg_data;
				hotp_pkg::REG_KEY2: key_q[127:64] <= cfg_data;
				hotp_pkg::REG_KEY3: key_q[63:0] <= cfg_data;
				hotp_pkg::REG_KLEN: klen_q <= cfg_data[5:0];
				hotp_pkg::REG_STEP: step_q <= cfg_data[31:0];
				hotp_pkg::REG_CTR: ctr_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && !busy;

	hotp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(s_axis_tuser),
		.out_taken(m_axis_tready), .sts(sts), .cmd(cmd), .busy(busy),
		.out_valid(m_axis_tvalid)
	);

	hotp_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(s_axis_tuser), .moving_value(s_axis_tdata[31:0]),
		.digit_count(s_axis_tdata[35:32]), .key(key_q), .key_length(klen_q),
		.time_step(step_q), .init_counter(ctr_q), .code(code)
	);

	assign m_axis_tdata = {1'b0, code};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_out_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid) else $error("result repeated");
	a_code_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("code changed while held");
endmodule

// ----- sim/tb_hotp_totp_code_generator_core.sv -----
// Self-checking testbench for the HOTP/TOTP code generator core.
`timescale 1ns / 1ps
module tb_hotp_totp_code_generator_core;
	typedef struct {
		logic        func;
		logic [31:0] moving_value;
		logic [3:0]  digit_count;
	} otp_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	hotp_totp_code_generator_core dut (.*);

	always #5 clk = ~clk;

	// predictor copy of the registers
	logic [63:0] key_reg [4];
	logic [5:0]  klen_reg;
	logic [31:0] step_reg;
	logic [31:0] ctr_reg;

	otp_req_t    req_q [$];
	logic [30:0] code_q [$];
	int          errors = 0;
	bit          drv_busy = 1'b0;
	bit          in_taken = 1'b0;
	int          gap = 0;
	int          rx_stall = 0;

	function automatic logic [31:0] rotl(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha1_compress(ref logic [31:0] h [5], input logic [7:0] blk [64]);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endfunction

	// pad block then a short tail, digest out as 20 bytes
	function automatic void sha1_pad_tail(input logic [7:0] pad [64], input logic [7:0] tl [20],
			input int tlen, output logic [7:0] dig [20]);
		logic [31:0] h [5];
		logic [7:0]  blk [64];
		logic [63:0] bits;
		h = '{hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4};
		bits = 64'((64 + tlen) * 8);
		sha1_compress(h, pad);
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		for (int i = 0; i < tlen; i++) blk[i] = tl[i];
		blk[tlen] = 8'h80;
		for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
		sha1_compress(h, blk);
		for (int i = 0; i < 20; i++) dig[i] = h[i/4][31-8*(i%4) -: 8];
	endfunction

	function automatic logic [30:0] predict_code(otp_req_t r);
		logic [7:0]  ipad [64], opad [64], tl [20], inner [20], dig [20];
		logic [7:0]  kb;
		logic [31:0] factor, v, m;
		int          len, off;
		if (r.func)
			factor = (step_reg == 0) ? 32'hFFFF_FFFF : r.moving_value / step_reg;
		else
			factor = ctr_reg + r.moving_value;
		len = (klen_reg > 32) ? 32 : klen_reg;
		for (int i = 0; i < 64; i++) begin
			kb = (i < len) ? key_reg[i/8][63-8*(i%8) -: 8] : 8'h00;
			ipad[i] = kb ^ 8'h36;
			opad[i] = kb ^ 8'h5C;
		end
		for (int i = 0; i < 20; i++) tl[i] = 8'h00;
		{tl[4], tl[5], tl[6], tl[7]} = factor;
		sha1_pad_tail(ipad, tl, 8, inner);
		sha1_pad_tail(opad, inner, 20, dig);
		off = dig[19][3:0];
		v = {dig[off], dig[off+1], dig[off+2], dig[off+3]} & 32'h7FFF_FFFF;
		if (r.digit_count < 10) begin
			m = 1;
			for (int i = 0; i < r.digit_count; i++) m *= 10;
			v = v % m;
		end
		return v[30:0];
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// request beat seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) in_taken = 1'b1;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				drv_busy = 1'b0;
				in_taken = 1'b0;
			end
			if (!drv_busy) begin
				if (gap > 0) begin
					gap--;
					s_axis_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					otp_req_t r;
					r = req_q.pop_front();
					code_q.push_back(predict_code(r));
					s_axis_tdata  <= {4'h0, r.digit_count, r.moving_value};
					s_axis_tuser  <= r.func;
					s_axis_tvalid <= 1'b1;
					drv_busy = 1'b1;
					gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) rx_stall = pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (code_q.size() == 0) begin
				$error("code beat with nothing expected: %0d", m_axis_tdata[30:0]);
				errors++;
			end else begin
				logic [30:0] want;
				want = code_q.pop_front();
				if (m_axis_tdata[30:0] !== want) begin
					$error("code mismatch: expected %0d, got %0d", want, m_axis_tdata[30:0]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			hotp_pkg::REG_KLEN: klen_reg = val[5:0];
			hotp_pkg::REG_STEP: step_reg = val[31:0];
			hotp_pkg::REG_CTR:  ctr_reg = val[31:0];
			default:  key_reg[idx] = val;
		endcase
	endtask

	task automatic push_req(logic func, logic [31:0] mv, logic [3:0] dc);
		otp_req_t r;
		r.func = func; r.moving_value = mv; r.digit_count = dc;
		req_q.push_back(r);
	endtask

	// waits until all requests are out and all codes in, then settles
	task automatic drain();
		while (req_q.size() > 0 || drv_busy || code_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic random_reqs(int n);
		for (int i = 0; i < n; i++)
			push_req($urandom_range(0, 1), $urandom(),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(6, 8));
	endtask

	initial begin
		key_reg = '{default: '0};
		klen_reg = 6'd20;
		step_reg = 32'd30;
		ctr_reg = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults after reset, then the standard test key
		push_req(1'b0, 32'd0, 4'd6);
		push_req(1'b1, 32'd59, 4'd8);
		drain();
		write_reg(hotp_pkg::REG_KEY0, 64'h3132333435363738);
		write_reg(hotp_pkg::REG_KEY1, 64'h3930313233343536);
		write_reg(hotp_pkg::REG_KEY2, 64'h3738393000000000);
		write_reg(hotp_pkg::REG_KEY3, 64'hFFFFFFFFFFFFFFFF);
		for (int i = 0; i < 10; i++) push_req(1'b0, i, 4'd6);
		push_req(1'b1, 32'd59, 4'd8);
		push_req(1'b1, 32'd1111111109, 4'd8);
		push_req(1'b1, 32'hFFFF_FFFF, 4'd15);
		push_req(1'b0, 32'hFFFF_FFFF, 4'd0);
		push_req(1'b0, 32'd0, 4'd9);
		push_req(1'b0, 32'h8000_0000, 4'd10);
		drain();
		// zero time step, wrapping counter, over-long key, empty key
		write_reg(hotp_pkg::REG_STEP, 64'h0);
		write_reg(hotp_pkg::REG_CTR, 64'hFFFF_FFFF);
		write_reg(hotp_pkg::REG_KLEN, 64'd63);
		push_req(1'b1, 32'd12345, 4'd6);
		push_req(1'b0, 32'd1, 4'd7);
		push_req(1'b0, 32'hFFFF_FFFF, 4'd15);
		drain();
		write_reg(hotp_pkg::REG_KLEN, 64'd0);
		write_reg(hotp_pkg::REG_STEP, 64'hFFFF_FFFF);
		push_req(1'b1, 32'hFFFF_FFFF, 4'd6);
		push_req(1'b1, 32'hFFFF_FFFE, 4'd6);
		drain();

		// random phases with random settings
		for (int p = 0; p < 8; p++) begin
			for (int w = 0; w < 4; w++) write_reg(3'(w), {$urandom(), $urandom()});
			write_reg(hotp_pkg::REG_KLEN, (p == 0) ? 64'd32 : 64'($urandom_range(0, 63)));
			write_reg(hotp_pkg::REG_STEP, (p == 1) ? 64'd1 : $urandom_range(0, 3) == 0 ?
				64'(32'($urandom())) : 64'($urandom_range(1, 120)));
			write_reg(hotp_pkg::REG_CTR, 64'(32'($urandom())));
			random_reqs(48);
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/hotp_pkg.sv
sv/hotp_ctrl.sv
sv/hotp_dp.sv
sv/hotp_totp_code_generator_core.sv
sim/tb_hotp_totp_code_generator_core.sv
